[rtl/core/bmpd_pkg.sv]
package bmpd_pkg;

  // Default largest accepted image width or height, in pixels.
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  // Header byte positions at which a field is complete.
  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] POS_SIG_B      = 6'd0;
  localparam logic [POS_W-1:0] POS_SIG_M      = 6'd1;
  localparam logic [POS_W-1:0] POS_OFFSET_END = 6'd13;
  localparam logic [POS_W-1:0] POS_HSIZE_END  = 6'd17;
  localparam logic [POS_W-1:0] POS_INFO_START = 6'd18;
  // Forty-byte info header.
  localparam logic [POS_W-1:0] POS_L_WIDTH    = 6'd21;
  localparam logic [POS_W-1:0] POS_L_HEIGHT   = 6'd25;
  localparam logic [POS_W-1:0] POS_L_BPP      = 6'd29;
  localparam logic [POS_W-1:0] POS_L_COMPR    = 6'd33;
  // Twelve-byte core header.
  localparam logic [POS_W-1:0] POS_S_WIDTH    = 6'd19;
  localparam logic [POS_W-1:0] POS_S_HEIGHT   = 6'd21;
  localparam logic [POS_W-1:0] POS_S_BPP      = 6'd25;

  localparam logic [7:0]  SIG_B        = 8'h42;
  localparam logic [7:0]  SIG_M        = 8'h4D;
  localparam logic [31:0] HSIZE_LONG   = 32'd40;
  localparam logic [31:0] HSIZE_SHORT  = 32'd12;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [31:0] MIN_OFS_LONG  = 32'd34;
  localparam logic [31:0] MIN_OFS_SHORT = 32'd26;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIGNATURE = 3'd1,
    ERR_HSIZE     = 3'd2,
    ERR_BPP       = 3'd3,
    ERR_COMPRESS  = 3'd4,
    ERR_DIM       = 3'd5,
    ERR_OFFSET    = 3'd6
  } err_e;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
    logic [2:0] error_code;
  } out_word_t;

  // Verdict of the header checker for one header byte.
  typedef struct packed {
    err_e        err;
    logic        set_offset;
    logic        set_long;
    logic        set_short;
    logic        set_width;
    logic        set_height;
    logic        to_skip;
    logic [31:0] dim_val;
  } hdr_res_t;

endpackage

[rtl/core/bmpd_hdr_check.sv]
module bmpd_hdr_check import bmpd_pkg::*; #(
  parameter int unsigned MaxDim = MAX_DIM_DEFAULT
) (
  input  logic [POS_W-1:0] pos_i,
  input  logic [31:0]      word_i,
  input  logic             short_hdr_i,
  input  logic [31:0]      offset_i,
  output hdr_res_t         res_o
);

  logic [15:0] half;
  logic [7:0]  newest;

  assign half   = word_i[31:16];
  assign newest = word_i[31:24];

  function automatic logic dim_ok(input logic [31:0] v);
    return (v != 32'd0) && (v <= 32'(MaxDim));
  endfunction

  always_comb begin
    res_o         = '0;
    res_o.err     = ERR_NONE;
    res_o.dim_val = short_hdr_i ? {16'd0, half} : word_i;
    if (pos_i == POS_SIG_B) begin
      if (newest != SIG_B) res_o.err = ERR_SIGNATURE;
    end else if (pos_i == POS_SIG_M) begin
      if (newest != SIG_M) res_o.err = ERR_SIGNATURE;
    end else if (pos_i == POS_OFFSET_END) begin
      res_o.set_offset = 1'b1;
    end else if (pos_i == POS_HSIZE_END) begin
      if (word_i == HSIZE_LONG) res_o.set_long = 1'b1;
      else if (word_i == HSIZE_SHORT) res_o.set_short = 1'b1;
      else res_o.err = ERR_HSIZE;
    end else if (pos_i >= POS_INFO_START) begin
      if (!short_hdr_i) begin
        if (pos_i == POS_L_WIDTH || pos_i == POS_L_HEIGHT) begin
          if (!dim_ok(word_i)) res_o.err = ERR_DIM;
          else if (pos_i == POS_L_WIDTH) res_o.set_width = 1'b1;
          else res_o.set_height = 1'b1;
        end else if (pos_i == POS_L_BPP) begin
          if (half != BPP_24) res_o.err = ERR_BPP;
        end else if (pos_i == POS_L_COMPR) begin
          if (word_i != 32'd0) res_o.err = ERR_COMPRESS;
          else if (offset_i < MIN_OFS_LONG) res_o.err = ERR_OFFSET;
          else res_o.to_skip = 1'b1;
        end
      end else begin
        if (pos_i == POS_S_WIDTH || pos_i == POS_S_HEIGHT) begin
          if (!dim_ok({16'd0, half})) res_o.err = ERR_DIM;
          else if (pos_i == POS_S_WIDTH) res_o.set_width = 1'b1;
          else res_o.set_height = 1'b1;
        end else if (pos_i == POS_S_BPP) begin
          if (half != BPP_24) res_o.err = ERR_BPP;
          else if (offset_i < MIN_OFS_SHORT) res_o.err = ERR_OFFSET;
          else res_o.to_skip = 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/bmp24_stream_decoder.sv]
// Streaming decoder for 24-bit uncompressed BMP files.
// The input channel (in_valid_i, in_ready_o, in_i) carries one file byte per
// word, with start_of_file set on byte 0 of a new file; that flag restarts the
// parser at once. The output channel (out_valid_o, out_ready_i, out_o) carries
// one RGB pixel per three stored BGR bytes, rows in stored order, with
// last_pixel on the final pixel, or a single word with a non-zero error_code
// when the header is rejected. Row padding and bytes before the pixel data are
// dropped without a result. After an error or the last pixel, all bytes are
// swallowed until the next start_of_file.
// A byte is registered on acceptance in the input register and decoded from
// there into the result register, which offers each result until it is
// taken. One byte is taken in every cycle; the sole limit is the output
// register, which holds back the decode stage, and so the input, while the
// receiver stalls it.
// The skip over bytes ahead of the pixel data uses a 32-bit position counter
// and compare, one byte per cycle while the output register does not stall.
// Reset empties both registers and puts the parser at header byte 0, so a file
// may start even without start_of_file after reset.
module bmp24_stream_decoder import bmpd_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_o
);

  // Dimension counters hold up to MAX_DIM; row byte counters up to a padded row.
  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned RbcW = $clog2(3 * MAX_DIM + 4);

  // Input register and result register.
  logic      in_valid_q, in_valid_d;
  in_word_t  in_q, in_d;
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;

  // Parser state.
  phase_e          phase_q, phase_d, phase_c;
  logic [31:0]     pos_q, pos_d, pos_c;
  logic [31:0]     shift_q, shift_d, shift_c, shift_n;
  logic [31:0]     offset_q, offset_d;
  logic            short_q, short_d;
  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [DimW-1:0] col_q, col_d, col_c;
  logic [DimW-1:0] row_q, row_d, row_c;
  logic [RbcW-1:0] rbc_q, rbc_d, rbc_c, rbc_n;
  logic [RbcW-1:0] row_data_q, row_data_d;
  logic [RbcW-1:0] row_len_q, row_len_d;
  logic [15:0]     held_q, held_d;
  logic [1:0]      pbi_q, pbi_d, pbi_c;

  logic            advance, proc, pix_go, last;
  logic [7:0]      b;
  logic [RbcW-1:0] new_w;
  hdr_res_t        hres;

  // The decode stage moves whenever the result register is free or draining.
  assign advance     = !out_valid_q || out_ready_i;
  assign proc        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign b           = in_q.file_byte;

  // A start flag makes the byte decode as byte 0 from cleared state.
  assign phase_c = in_q.start_of_file ? PH_HEADER : phase_q;
  assign pos_c   = in_q.start_of_file ? 32'd0 : pos_q;
  assign shift_c = in_q.start_of_file ? 32'd0 : shift_q;
  assign col_c   = in_q.start_of_file ? '0 : col_q;
  assign row_c   = in_q.start_of_file ? '0 : row_q;
  assign rbc_c   = in_q.start_of_file ? '0 : rbc_q;
  assign pbi_c   = in_q.start_of_file ? 2'd0 : pbi_q;

  // Header fields are little-endian, so the newest byte enters at the top.
  assign shift_n = {b, shift_c[31:8]};
  assign new_w   = RbcW'(hres.dim_val[DimW-1:0]);
  assign rbc_n   = rbc_c + RbcW'(1);

  bmpd_hdr_check #(
    .MaxDim(MAX_DIM)
  ) u_hdr_check (
    .pos_i      (pos_c[POS_W-1:0]),
    .word_i     (shift_n),
    .short_hdr_i(short_q),
    .offset_i   (offset_q),
    .res_o      (hres)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    in_d        = in_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    phase_d     = phase_q;
    pos_d       = pos_q;
    shift_d     = shift_q;
    offset_d    = offset_q;
    short_d     = short_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    rbc_d       = rbc_q;
    row_data_d  = row_data_q;
    row_len_d   = row_len_q;
    held_d      = held_q;
    pbi_d       = pbi_q;
    pix_go      = 1'b0;
    last        = 1'b0;

    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_d       = in_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    if (advance) out_valid_d = 1'b0;

    if (proc) begin
      phase_d = phase_c;
      pos_d   = pos_c;
      shift_d = shift_c;
      col_d   = col_c;
      row_d   = row_c;
      rbc_d   = rbc_c;
      pbi_d   = pbi_c;

      case (phase_c)
        PH_HEADER: begin
          shift_d = shift_n;
          pos_d   = pos_c + 32'd1;
          if (hres.set_offset) offset_d = shift_n;
          if (hres.set_long) short_d = 1'b0;
          if (hres.set_short) short_d = 1'b1;
          if (hres.set_width) begin
            width_d    = hres.dim_val[DimW-1:0];
            row_data_d = new_w + new_w + new_w;
            row_len_d  = new_w + new_w + new_w + RbcW'(new_w[1:0]);
          end
          if (hres.set_height) height_d = hres.dim_val[DimW-1:0];
          if (hres.err != ERR_NONE) begin
            phase_d           = PH_IDLE;
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.error_code  = hres.err;
          end else if (hres.to_skip) begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (pos_c < offset_q) begin
            pos_d = pos_c + 32'd1;
          end else begin
            phase_d = PH_PIXELS;
            pix_go  = 1'b1;
          end
        end
        PH_PIXELS: pix_go = 1'b1;
        default: ;
      endcase

      if (pix_go) begin
        if (rbc_c < row_data_q) begin
          case (pbi_c)
            2'd0: begin
              held_d = {8'd0, b};
              pbi_d  = 2'd1;
            end
            2'd1: begin
              held_d[15:8] = b;
              pbi_d        = 2'd2;
            end
            default: begin
              last = (col_c + DimW'(1) == width_q) && (row_c + DimW'(1) == height_q);
              out_valid_d      = 1'b1;
              out_d.red        = b;
              out_d.green      = held_q[15:8];
              out_d.blue       = held_q[7:0];
              out_d.last_pixel = last;
              out_d.error_code = ERR_NONE;
              col_d            = col_c + DimW'(1);
              pbi_d            = 2'd0;
            end
          endcase
        end
        // Pad bytes count towards the row but give nothing.
        if (rbc_n >= row_len_q) begin
          rbc_d = '0;
          col_d = '0;
          pbi_d = 2'd0;
          row_d = row_c + DimW'(1);
        end else begin
          rbc_d = rbc_n;
        end
        if (last) phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      pos_q       <= 32'd0;
      col_q       <= '0;
      row_q       <= '0;
      rbc_q       <= '0;
      pbi_q       <= 2'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      col_q       <= col_d;
      row_q       <= row_d;
      rbc_q       <= rbc_d;
      pbi_q       <= pbi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    out_q      <= out_d;
    shift_q    <= shift_d;
    offset_q   <= offset_d;
    short_q    <= short_d;
    width_q    <= width_d;
    height_q   <= height_d;
    row_data_q <= row_data_d;
    row_len_q  <= row_len_d;
    held_q     <= held_d;
  end

`ifndef NO_ASSERTIONS
  // An error word carries no pixel.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.error_code != ERR_NONE) |->
      (out_o.red == 8'd0) && (out_o.green == 8'd0) && (out_o.blue == 8'd0) &&
      !out_o.last_pixel)
    else $error("error word carries pixel data");

  // The final pixel stops the parser until the next file.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && last |=> (phase_q == PH_IDLE) && out_valid_q && out_q.last_pixel)
    else $error("parser still active after the last pixel");

  // The byte index within a pixel never reaches three.
  a_pbi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pbi_q != 2'd3)
    else $error("pixel byte index out of range");

  // While pixels stream, the row byte counter stays inside the padded row.
  a_rbc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (rbc_q < row_len_q))
    else $error("row byte counter beyond padded row");

  // A word is only loaded when the result register could take it.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");
`endif

endmodule
